// ===== src/opn_pkg.sv =====
`default_nettype none
package opn_pkg;

   localparam int CW      = 32;           // coordinate width
   localparam int FB      = 16;           // fraction bits
   localparam int NUM_W   = CW + 2;       // signed numerator
   localparam int DEN_W   = CW + 1;       // signed span
   localparam int NMAG_W  = CW + 1;       // numerator magnitude
   localparam int DMAG_W  = CW;           // span magnitude
   localparam int DV_W    = CW + FB + 2;  // scaled and rounded dividend
   localparam int CMP_W   = DV_W + CW;    // compare width for shifted divisor
   localparam int Q_W     = CW + 1;       // quotient, top two bits flag overflow
   localparam int DIV_STG = CW + 1;       // one quotient bit per stage
   localparam int NSTG    = DIV_STG + 3;  // front end adds three stages

   typedef logic signed [CW-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam coord_type COORD_ONE = coord_type'(64'd1 << FB);
   localparam coord_type COORD_NEG_ONE = coord_type'(-(64'sd1 <<< FB));

   typedef enum logic [2:0] {
      CSR_LEFT   = 3'd0,
      CSR_RIGHT  = 3'd1,
      CSR_BOTTOM = 3'd2,
      CSR_TOP    = 3'd3,
      CSR_NEAR   = 3'd4,
      CSR_FAR    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [NSTG-1:0] load;
   } lane_ctrl_type;

   typedef struct packed {
      logic [Q_W-1:0] quot;
      logic           neg;
      logic           zero;
      logic           num_neg;
   } lane_res_type;

endpackage
`default_nettype wire

// ===== src/opn_if.sv =====
`default_nettype none
interface opn_req_if;
   logic                valid;
   logic                ready;
   opn_pkg::coord_type  point_x;
   opn_pkg::coord_type  point_y;
   opn_pkg::coord_type  point_z;

   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface opn_rsp_if;
   logic                valid;
   logic                ready;
   opn_pkg::coord_type  norm_x;
   opn_pkg::coord_type  norm_y;
   opn_pkg::coord_type  norm_z;
   logic [2:0]          span_error;

   modport source (output valid, norm_x, norm_y, norm_z, span_error, input ready);
   modport sink (input valid, norm_x, norm_y, norm_z, span_error, output ready);
endinterface
`default_nettype wire

// ===== src/orthographic_projection_normalize.sv =====
`default_nettype none
// Orthographic projection of a Q16.16 point into the normalized view volume.
// req_chan carries one point (x, y, z) per word; rsp_chan returns one word
// per point: normalized x, y, flipped z, saturated, and a three-bit mask of
// axes whose view box span is zero. Results come back in input order. The
// user writes the six view box bounds via csr_we/csr_index/csr_wdata with
// no point in flight; the block does not enforce it. Index > 5 is ignored.
// Three lanes (x, y, z) run side by side, each a 36-stage pipeline: three
// front-end stages form numerator, magnitudes and rounded dividend, then a
// restoring divider resolves one quotient bit per stage. The output register
// merges the lanes and applies the sign and saturation.
// One point per cycle is accepted when the receiver keeps up.
// When rsp_chan stalls, each stage holds only while everything after it is
// full, so empty stages keep filling and req_chan.ready drops only once the
// whole pipe is occupied.
// Synchronous reset empties the pipe and restores the bounds to the
// [-1.0, +1.0] cube.
module orthographic_projection_normalize (
   input  wire logic                   clock,
   input  wire logic                   reset,
   opn_req_if.sink                     req_chan,
   opn_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_we,
   input  wire opn_pkg::csr_index_type csr_index,
   input  wire opn_pkg::coord_type     csr_wdata
);
   import opn_pkg::*;

   coord_type left_ff, right_ff, bottom_ff, top_ff, near_ff, far_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= COORD_NEG_ONE;
         right_ff  <= COORD_ONE;
         bottom_ff <= COORD_NEG_ONE;
         top_ff    <= COORD_ONE;
         near_ff   <= COORD_NEG_ONE;
         far_ff    <= COORD_ONE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEFT:   left_ff   <= csr_wdata;
            CSR_RIGHT:  right_ff  <= csr_wdata;
            CSR_BOTTOM: bottom_ff <= csr_wdata;
            CSR_TOP:    top_ff    <= csr_wdata;
            CSR_NEAR:   near_ff   <= csr_wdata;
            CSR_FAR:    far_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline occupancy; stage s loads if out_free or any of s..NSTG-1 is empty
   logic [NSTG-1:0] valid_ff, valid_in, room;
   logic            out_free;
   lane_ctrl_type   ctrl;
   lane_res_type    res_x, res_y, res_z;

   for (genvar s = 0; s < NSTG; s++) begin : g_stage
      assign room[s] = out_free | ~(&valid_ff[NSTG-1:s]);
      if (s == 0) begin : g_head
         assign valid_in[s] = room[s] ? req_chan.valid : valid_ff[s];
      end else begin : g_body
         assign valid_in[s] = room[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load      = room;
   assign req_chan.ready = room[0];

   opn_lane u_lane_x (
      .clock (clock),
      .point (req_chan.point_x),
      .lo    (left_ff),
      .hi    (right_ff),
      .flip  (1'b0),
      .ctrl  (ctrl),
      .res   (res_x)
   );

   opn_lane u_lane_y (
      .clock (clock),
      .point (req_chan.point_y),
      .lo    (bottom_ff),
      .hi    (top_ff),
      .flip  (1'b0),
      .ctrl  (ctrl),
      .res   (res_y)
   );

   opn_lane u_lane_z (
      .clock (clock),
      .point (req_chan.point_z),
      .lo    (near_ff),
      .hi    (far_ff),
      .flip  (1'b1),
      .ctrl  (ctrl),
      .res   (res_z)
   );

   opn_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .res_x    (res_x),
      .res_y    (res_y),
      .res_z    (res_z),
      .in_valid (valid_ff[NSTG-1]),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      out_free |-> req_chan.ready)
      else $error("input stalled while output side is free");
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |=> valid_ff[0])
      else $error("first stage lost a word while stalled");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NSTG-1] && !out_free |=> valid_ff[NSTG-1])
      else $error("last stage dropped a word under backpressure");
`endif

endmodule
`default_nettype wire

// ===== src/opn_lane.sv =====
`default_nettype none
module opn_lane (
   input  wire logic                   clock,
   input  wire opn_pkg::coord_type     point,
   input  wire opn_pkg::coord_type     lo,
   input  wire opn_pkg::coord_type     hi,
   input  wire logic                   flip,
   input  wire opn_pkg::lane_ctrl_type ctrl,
   output opn_pkg::lane_res_type       res
);
   import opn_pkg::*;

   // stage A: numerator and span
   logic signed [NUM_W-1:0] num_ff, num_in, sum, twop;
   logic signed [DEN_W-1:0] den_ff, den_in;

   assign sum    = NUM_W'(lo) + NUM_W'(hi);
   assign twop   = NUM_W'(point) <<< 1;
   assign num_in = flip ? (sum - twop) : (twop - sum);
   assign den_in = DEN_W'(hi) - DEN_W'(lo);

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   // stage B: magnitudes and signs
   logic [NMAG_W-1:0] nmag_ff, nmag_in;
   logic [DMAG_W-1:0] dmagb_ff, dmagb_in;
   logic              nnegb_ff, negb_ff, zerob_ff;

   assign nmag_in  = num_ff[NUM_W-1] ? NMAG_W'(-num_ff) : NMAG_W'(num_ff);
   assign dmagb_in = den_ff[DEN_W-1] ? DMAG_W'(-den_ff) : DMAG_W'(den_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         nmag_ff  <= nmag_in;
         dmagb_ff <= dmagb_in;
         nnegb_ff <= num_ff[NUM_W-1];
         negb_ff  <= num_ff[NUM_W-1] ^ den_ff[DEN_W-1];
         zerob_ff <= (den_ff == '0);
      end
   end

   // stage C: scale and add half the divisor for round to nearest
   logic [DV_W-1:0]   dv_ff, dv_in;
   logic [DMAG_W-1:0] dmagc_ff;
   logic              nnegc_ff, negc_ff, zeroc_ff;

   assign dv_in = (DV_W'(nmag_ff) << FB) + DV_W'(dmagb_ff >> 1);

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         dv_ff    <= dv_in;
         dmagc_ff <= dmagb_ff;
         nnegc_ff <= nnegb_ff;
         negc_ff  <= negb_ff;
         zeroc_ff <= zerob_ff;
      end
   end

   // restoring divider, one quotient bit per stage, MSB first
   logic [DV_W-1:0]   rem_ff  [DIV_STG];
   logic [Q_W-1:0]    quot_ff [DIV_STG];
   logic [DMAG_W-1:0] dmag_ff [DIV_STG];
   logic              nneg_ff [DIV_STG];
   logic              neg_ff  [DIV_STG];
   logic              zero_ff [DIV_STG];

   for (genvar j = 0; j < DIV_STG; j++) begin : g_div
      localparam int SH = CW - j;
      logic [DV_W-1:0]   r_src, rem_in;
      logic [Q_W-1:0]    q_src, quot_in;
      logic [DMAG_W-1:0] d_src;
      logic              nneg_src, neg_src, zero_src;
      logic [CMP_W-1:0]  shifted, diff;
      logic              ge;

      if (j == 0) begin : g_first
         assign r_src    = dv_ff;
         assign q_src    = '0;
         assign d_src    = dmagc_ff;
         assign nneg_src = nnegc_ff;
         assign neg_src  = negc_ff;
         assign zero_src = zeroc_ff;
      end else begin : g_next
         assign r_src    = rem_ff[j-1];
         assign q_src    = quot_ff[j-1];
         assign d_src    = dmag_ff[j-1];
         assign nneg_src = nneg_ff[j-1];
         assign neg_src  = neg_ff[j-1];
         assign zero_src = zero_ff[j-1];
      end

      assign shifted = CMP_W'(d_src) << SH;
      assign ge      = CMP_W'(r_src) >= shifted;
      assign diff    = CMP_W'(r_src) - shifted;
      assign rem_in  = ge ? DV_W'(diff) : r_src;
      assign quot_in = q_src | (ge ? (Q_W'(1) << SH) : '0);

      always_ff @(posedge clock) begin
         if (ctrl.load[3+j]) begin
            rem_ff[j]  <= rem_in;
            quot_ff[j] <= quot_in;
            dmag_ff[j] <= d_src;
            nneg_ff[j] <= nneg_src;
            neg_ff[j]  <= neg_src;
            zero_ff[j] <= zero_src;
         end
      end
   end

   assign res.quot    = quot_ff[DIV_STG-1];
   assign res.neg     = neg_ff[DIV_STG-1];
   assign res.zero    = zero_ff[DIV_STG-1];
   assign res.num_neg = nneg_ff[DIV_STG-1];

endmodule
`default_nettype wire

// ===== src/opn_merge.sv =====
`default_nettype none
module opn_merge (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire opn_pkg::lane_res_type res_x,
   input  wire opn_pkg::lane_res_type res_y,
   input  wire opn_pkg::lane_res_type res_z,
   input  wire logic                  in_valid,
   output logic                       free,
   opn_rsp_if.source                  rsp_chan
);
   import opn_pkg::*;

   function automatic coord_type sat_value(lane_res_type r);
      logic      big;
      coord_type v;
      big = r.quot[Q_W-1] | r.quot[Q_W-2];
      if (r.zero) begin
         v = r.num_neg ? COORD_MIN : COORD_MAX;
      end else if (r.neg) begin
         v = big ? COORD_MIN : coord_type'(~r.quot[CW-1:0] + 1'b1);
      end else begin
         v = big ? COORD_MAX : coord_type'(r.quot[CW-1:0]);
      end
      return v;
   endfunction

   logic      valid_ff;
   coord_type nx_ff, ny_ff, nz_ff;
   logic [2:0] err_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (free) begin
         nx_ff  <= sat_value(res_x);
         ny_ff  <= sat_value(res_y);
         nz_ff  <= sat_value(res_z);
         err_ff <= {res_z.zero, res_y.zero, res_x.zero};
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.norm_x     = nx_ff;
   assign rsp_chan.norm_y     = ny_ff;
   assign rsp_chan.norm_z     = nz_ff;
   assign rsp_chan.span_error = err_ff;

`ifndef NO_ASSERTIONS
   a_err_x: assert property (@(posedge clock) disable iff (reset)
      valid_ff && err_ff[0] |-> nx_ff == COORD_MAX || nx_ff == COORD_MIN)
      else $error("x span error without saturated result");
   a_err_y: assert property (@(posedge clock) disable iff (reset)
      valid_ff && err_ff[1] |-> ny_ff == COORD_MAX || ny_ff == COORD_MIN)
      else $error("y span error without saturated result");
   a_err_z: assert property (@(posedge clock) disable iff (reset)
      valid_ff && err_ff[2] |-> nz_ff == COORD_MAX || nz_ff == COORD_MIN)
      else $error("z span error without saturated result");
`endif

endmodule
`default_nettype wire
